/* rtl/cv3_pkg.sv */
// cv3_pkg: shared constants, register indexes and transaction types for the
// 3x3 pixel-stream convolution. No dependencies.
`default_nettype none

package cv3_pkg;

   localparam int PIX_W        = 8;
   localparam int COEF_W       = 8;
   localparam int TAPS         = 9;
   localparam int SCALE_W      = 17;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 24;
   localparam int HEIGHT_W     = 13;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int MIN_DIM      = 3;
   // row counter saturates at all ones, which is above any usable height
   localparam int ROW_W        = 13;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_KERNEL_TOP    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KERNEL_MIDDLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_KERNEL_BOTTOM = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_Q16     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT  = 3'd5;

   // reset values
   localparam logic [CSR_DATA_W-1:0] RST_KERNEL_TOP    = 24'h000000;
   localparam logic [CSR_DATA_W-1:0] RST_KERNEL_MIDDLE = 24'h000100;
   localparam logic [CSR_DATA_W-1:0] RST_KERNEL_BOTTOM = 24'h000000;
   localparam logic [SCALE_W-1:0]    RST_SCALE_Q16     = 17'd65536;
   localparam int                    RST_FRAME_WIDTH   = 640;
   localparam int                    RST_FRAME_HEIGHT  = 480;

   // command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // one queued window, index row*3+col
   typedef struct packed {
      logic [TAPS-1:0][PIX_W-1:0] pix;
      logic                       row_end;
      logic                       frame_end;
   } win_entry_type;

   typedef struct packed {
      logic full;
      logic almost_full;
      logic empty;
   } queue_status_type;

   // coefficient index row*3+col, signed bytes
   typedef struct packed {
      logic [TAPS-1:0][COEF_W-1:0] coef;
      logic [SCALE_W-1:0]          scale;
   } kernel_cfg_type;

endpackage

`default_nettype wire

/* rtl/cv3_front.sv */
// cv3_front: raster counters, two line stores and the 3x3 window; pushes one
// window per result into the queue. Depends on cv3_pkg.
`default_nettype none

module cv3_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [cv3_pkg::PIX_W-1:0]            req_tdata,
   input  logic [0:0]                           req_tuser,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]       w_lim,
   input  logic [cv3_pkg::HEIGHT_W-1:0]         h_lim,
   input  logic [$clog2(MAX_WIDTH*cv3_pkg::HEIGHT_LIMIT):0] frame_size,
   input  cv3_pkg::queue_status_type            q_status,
   output logic                                 q_push,
   output cv3_pkg::win_entry_type               q_entry
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int CNT_W = $clog2(MAX_WIDTH+1);
   localparam int OC_W  = $clog2(MAX_WIDTH*cv3_pkg::HEIGHT_LIMIT);
   localparam int SZ_W  = OC_W + 1;
   localparam int ROW_W = cv3_pkg::ROW_W;
   localparam int PW    = cv3_pkg::PIX_W;

   typedef struct packed {
      logic col_zero;
      logic row_ge1;
      logic row_ge2;
      logic emit;
      logic done;
   } b_info_type;

   function automatic logic [ROW_W-1:0] row_step(input logic [ROW_W-1:0] r);
      row_step = (r == '1) ? r : r + ROW_W'(1);
   endfunction

   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [OC_W-1:0]  oc_ff, oc_in;

   logic [PW-1:0] upper_mem [MAX_WIDTH];
   logic [PW-1:0] lower_mem [MAX_WIDTH];

   logic [PW-1:0] rd_up_ff, rd_lo_ff, b_pix_ff;
   logic [CW-1:0] b_addr_ff;
   b_info_type    b_info_ff, a_info;
   logic          b_valid_ff, b_valid_in;

   logic [cv3_pkg::TAPS-1:0][PW-1:0] win_ff, win_in, new_win, out_win;

   logic             accept, wrap, beyond, ignore, last_col;
   logic [CW-1:0]    cur_col;
   logic [ROW_W-1:0] cur_row;
   logic [PW-1:0]    pix, top_px, mid_px;

   // room is reserved for the window still in stage B
   assign req_tready = (b_valid_ff && b_info_ff.emit) ? !q_status.almost_full
                                                      : !q_status.full;
   assign accept = req_tvalid && req_tready;

   // stage A: position of this transaction
   always_comb begin
      wrap    = CNT_W'(col_ff) >= w_lim;
      cur_col = wrap ? '0 : col_ff;
      cur_row = wrap ? row_step(row_ff) : row_ff;
      beyond  = cur_row >= ROW_W'(h_lim);
      ignore  = (req_tuser[0] == cv3_pkg::CMD_FLUSH) && !beyond;
      pix     = beyond ? '0 : req_tdata;
      last_col = (CNT_W'(cur_col) + CNT_W'(1)) >= w_lim;

      a_info.col_zero = cur_col == '0;
      a_info.row_ge1  = cur_row != '0;
      a_info.row_ge2  = cur_row > ROW_W'(1);
      a_info.emit     = a_info.col_zero ? a_info.row_ge2 : a_info.row_ge1;
      a_info.done     = a_info.emit && ((SZ_W'(oc_ff) + SZ_W'(1)) >= frame_size);

      col_in = col_ff;
      row_in = row_ff;
      oc_in  = oc_ff;
      if (accept) begin
         if (ignore) begin
            // a flush mid-frame still applies the column wrap
            col_in = cur_col;
            row_in = cur_row;
         end else if (a_info.done) begin
            col_in = '0;
            row_in = '0;
            oc_in  = '0;
         end else begin
            col_in = last_col ? '0 : cur_col + CW'(1);
            row_in = last_col ? row_step(cur_row) : cur_row;
            oc_in  = a_info.emit ? oc_ff + OC_W'(1) : oc_ff;
         end
      end
      b_valid_in = accept && !ignore;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         oc_ff      <= '0;
         b_valid_ff <= 1'b0;
         win_ff     <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         oc_ff      <= oc_in;
         b_valid_ff <= b_valid_in;
         win_ff     <= win_in;
      end
   end

   // lower store: read-first, new pixel written at the same column
   always_ff @(posedge clock) begin
      if (b_valid_in) begin
         rd_lo_ff           <= lower_mem[cur_col];
         lower_mem[cur_col] <= pix;
      end
   end

   // upper store: takes the old lower entry in the following cycle
   always_ff @(posedge clock) begin
      if (b_valid_in) begin
         rd_up_ff <= upper_mem[cur_col];
      end
      if (b_valid_ff) begin
         upper_mem[b_addr_ff] <= rd_lo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid_in) begin
         b_addr_ff <= cur_col;
         b_pix_ff  <= pix;
         b_info_ff <= a_info;
      end
   end

   // stage B: window update
   always_comb begin
      top_px = b_info_ff.row_ge2 ? rd_up_ff : '0;
      mid_px = b_info_ff.row_ge1 ? rd_lo_ff : '0;
      new_win = '0;
      out_win = '0;
      for (int r = 0; r < 3; r++) begin
         if (b_info_ff.col_zero) begin
            // result for the last column of the previous row, zero on the right
            out_win[3*r]     = win_ff[3*r+1];
            out_win[3*r+1]   = win_ff[3*r+2];
            out_win[3*r+2]   = '0;
         end else begin
            new_win[3*r]     = win_ff[3*r+1];
            new_win[3*r+1]   = win_ff[3*r+2];
         end
      end
      new_win[2] = top_px;
      new_win[5] = mid_px;
      new_win[8] = b_pix_ff;
      if (!b_info_ff.col_zero) begin
         out_win = new_win;
      end
      if (!b_valid_ff) begin
         win_in = win_ff;
      end else if (b_info_ff.done) begin
         win_in = '0;
      end else begin
         win_in = new_win;
      end
   end

   assign q_push            = b_valid_ff && b_info_ff.emit;
   assign q_entry.pix       = out_win;
   assign q_entry.row_end   = b_info_ff.col_zero;
   assign q_entry.frame_end = b_info_ff.done;

endmodule

`default_nettype wire

/* rtl/cv3_queue.sv */
// cv3_queue: short register queue of windows between front and back.
// Depends on cv3_pkg.
`default_nettype none

module cv3_queue #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cv3_pkg::win_entry_type    push_entry,
   input  logic                      pop,
   output cv3_pkg::win_entry_type    head,
   output cv3_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   cv3_pkg::win_entry_type slot_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head               = slot_ff[rd_ptr_ff];
   assign status.empty       = count_ff == '0;
   assign status.full        = count_ff == CNT_W'(DEPTH);
   assign status.almost_full = count_ff >= CNT_W'(DEPTH-1);

endmodule

`default_nettype wire

/* rtl/cv3_back.sv */
// cv3_back: five-stage tap products, sum, gain, rounding and saturation with
// the output register. Depends on cv3_pkg.
`default_nettype none

module cv3_back (
   input  logic                        clock,
   input  logic                        reset,
   input  cv3_pkg::kernel_cfg_type     kcfg,
   input  cv3_pkg::queue_status_type   q_status,
   input  cv3_pkg::win_entry_type      q_head,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [cv3_pkg::PIX_W-1:0]   rsp_tdata,
   output logic [0:0]                  rsp_tuser,
   output logic                        rsp_tlast
);

   localparam int TAPS = cv3_pkg::TAPS;
   localparam logic signed [37:0] ROUND_K = 38'sd32768;
   localparam logic signed [37:0] UNIT_K  = 38'sd65536;
   localparam logic [21:0]        SAT_K   = 22'd255;

   typedef struct packed {
      logic row_end;
      logic frame_end;
   } mark_type;

   logic adv;
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, rsp_valid_ff;
   mark_type s1_mark_ff, s2_mark_ff, s3_mark_ff, s4_mark_ff, out_mark_ff, head_mark;

   logic signed [15:0] s1_prod_ff [TAPS];
   logic signed [15:0] s1_prod_in [TAPS];
   logic [2:0][17:0]   s2_row_ff, s2_row_in;
   logic signed [19:0] s3_sum_ff, s3_sum_in;
   logic signed [36:0] s4_prod_ff, s4_prod_in;
   logic signed [37:0] s4_full;
   logic [7:0]         out_pix_ff, out_pix_in;
   logic signed [37:0] rnd;

   // the whole pipeline holds while a result waits
   assign adv   = !rsp_valid_ff || rsp_tready;
   assign q_pop = adv && !q_status.empty;

   assign head_mark.row_end   = q_head.row_end;
   assign head_mark.frame_end = q_head.frame_end;

   always_comb begin
      logic signed [16:0] full;
      for (int i = 0; i < TAPS; i++) begin
         full = $signed(kcfg.coef[i]) * $signed({1'b0, q_head.pix[i]});
         s1_prod_in[i] = full[15:0];
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s2_row_in[r] = {{2{s1_prod_ff[3*r][15]}},   s1_prod_ff[3*r]}
                      + {{2{s1_prod_ff[3*r+1][15]}}, s1_prod_ff[3*r+1]}
                      + {{2{s1_prod_ff[3*r+2][15]}}, s1_prod_ff[3*r+2]};
      end
      s3_sum_in = $signed({{2{s2_row_ff[0][17]}}, s2_row_ff[0]}
                        + {{2{s2_row_ff[1][17]}}, s2_row_ff[1]}
                        + {{2{s2_row_ff[2][17]}}, s2_row_ff[2]});
   end

   assign s4_full    = s3_sum_ff * $signed({1'b0, kcfg.scale});
   assign s4_prod_in = s4_full[36:0];

   // round half up, negative or small results give zero
   always_comb begin
      rnd = $signed({s4_prod_ff[36], s4_prod_ff}) + ROUND_K;
      if (rnd < UNIT_K) begin
         out_pix_in = '0;
      end else if (rnd[37:16] > SAT_K) begin
         out_pix_in = SAT_K[7:0];
      end else begin
         out_pix_in = rnd[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff      <= !q_status.empty;
         s2_v_ff      <= s1_v_ff;
         s3_v_ff      <= s2_v_ff;
         s4_v_ff      <= s3_v_ff;
         rsp_valid_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff  <= s1_prod_in;
         s1_mark_ff  <= head_mark;
         s2_row_ff   <= s2_row_in;
         s2_mark_ff  <= s1_mark_ff;
         s3_sum_ff   <= s3_sum_in;
         s3_mark_ff  <= s2_mark_ff;
         s4_prod_ff  <= s4_prod_in;
         s4_mark_ff  <= s3_mark_ff;
         out_pix_ff  <= out_pix_in;
         out_mark_ff <= s4_mark_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = out_pix_ff;
   assign rsp_tuser[0] = out_mark_ff.row_end;
   assign rsp_tlast    = out_mark_ff.frame_end;

endmodule

`default_nettype wire

/* rtl/convolution_3x3_pixel_stream.sv */
// convolution_3x3_pixel_stream: top level, register file, front, queue, back.
// Throughput one transaction per cycle while the queue has room; a result follows
// the transaction completing its neighbourhood (one row plus one pixel later).
// Back-pressure stalls the back pipeline; the front stops when the queue is full.
// Synchronous reset clears counters, window, pipeline and registers; line
// stores are not cleared. Depends on cv3_pkg, cv3_front, cv3_queue, cv3_back.
`default_nettype none

module convolution_3x3_pixel_stream #(
   parameter int MAX_WIDTH   = 1024,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input transactions
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [7:0] pixel_in
   input  logic [0:0]                           req_tuser,   // [0] command
   // results
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,   // [7:0] pixel_out
   output logic [0:0]                           rsp_tuser,   // [0] row_end
   output logic                                 rsp_tlast,   // frame_end
   // register writes
   input  logic                                 csr_we,
   input  logic [cv3_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cv3_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int CNT_W = $clog2(MAX_WIDTH+1);
   localparam int OC_W  = $clog2(MAX_WIDTH*cv3_pkg::HEIGHT_LIMIT);
   localparam int SZ_W  = OC_W + 1;
   localparam int HW    = cv3_pkg::HEIGHT_W;
   // frame area after reset, width clamped to the line store size
   localparam int RST_W_LIM = (cv3_pkg::RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                                  : cv3_pkg::RST_FRAME_WIDTH;
   localparam int RST_AREA  = RST_W_LIM * cv3_pkg::RST_FRAME_HEIGHT;

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   logic [cv3_pkg::CSR_DATA_W-1:0] k_top_ff, k_mid_ff, k_bot_ff;
   logic [cv3_pkg::SCALE_W-1:0]    scale_ff;
   logic [10:0]                    fw_ff;
   logic [HW-1:0]                  fh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_top_ff <= cv3_pkg::RST_KERNEL_TOP;
         k_mid_ff <= cv3_pkg::RST_KERNEL_MIDDLE;
         k_bot_ff <= cv3_pkg::RST_KERNEL_BOTTOM;
         scale_ff <= cv3_pkg::RST_SCALE_Q16;
         fw_ff    <= 11'(cv3_pkg::RST_FRAME_WIDTH);
         fh_ff    <= HW'(cv3_pkg::RST_FRAME_HEIGHT);
      end else if (csr_we) begin
         unique case (csr_index)
            cv3_pkg::REG_KERNEL_TOP:    k_top_ff <= csr_wdata;
            cv3_pkg::REG_KERNEL_MIDDLE: k_mid_ff <= csr_wdata;
            cv3_pkg::REG_KERNEL_BOTTOM: k_bot_ff <= csr_wdata;
            cv3_pkg::REG_SCALE_Q16:     scale_ff <= csr_wdata[cv3_pkg::SCALE_W-1:0];
            cv3_pkg::REG_FRAME_WIDTH:   fw_ff    <= csr_wdata[10:0];
            cv3_pkg::REG_FRAME_HEIGHT:  fh_ff    <= csr_wdata[HW-1:0];
            default: ;   // writes past the list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Frame limits: clamped width and height, registered area
   // ---------------------------------------------------------------
   logic [HW-1:0]          w_wide, h_wide;
   logic [CNT_W-1:0]       w_lim;
   logic [HW-1:0]          h_lim;
   logic [CNT_W+HW-1:0]    area;
   logic [SZ_W-1:0]        size_ff, size_in;

   always_comb begin
      w_wide = {2'b00, fw_ff};
      if (w_wide < HW'(cv3_pkg::MIN_DIM)) begin
         w_wide = HW'(cv3_pkg::MIN_DIM);
      end else if (w_wide > HW'(MAX_WIDTH)) begin
         w_wide = HW'(MAX_WIDTH);
      end
      h_wide = fh_ff;
      if (h_wide < HW'(cv3_pkg::MIN_DIM)) begin
         h_wide = HW'(cv3_pkg::MIN_DIM);
      end else if (h_wide > HW'(cv3_pkg::HEIGHT_LIMIT)) begin
         h_wide = HW'(cv3_pkg::HEIGHT_LIMIT);
      end
   end

   assign w_lim   = CNT_W'(w_wide);
   assign h_lim   = h_wide;
   assign area    = w_lim * h_lim;
   assign size_in = SZ_W'(area);

   // area is registered; the user must write only when idle (not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SZ_W'(RST_AREA);
      end else begin
         size_ff <= size_in;
      end
   end

   // ---------------------------------------------------------------
   // Front, queue, back
   // ---------------------------------------------------------------
   cv3_pkg::queue_status_type q_status;
   cv3_pkg::win_entry_type    q_entry, q_head;
   cv3_pkg::kernel_cfg_type   kcfg;
   logic                      q_push, q_pop;

   // coefficient n of the row register is column n; rows stacked top first
   assign kcfg.coef  = {k_bot_ff, k_mid_ff, k_top_ff};
   assign kcfg.scale = scale_ff;

   cv3_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .w_lim      (w_lim),
      .h_lim      (h_lim),
      .frame_size (size_ff),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   cv3_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   cv3_back u_back (
      .clock      (clock),
      .reset      (reset),
      .kcfg       (kcfg),
      .q_status   (q_status),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // the front's space reservation must never overrun the queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("window pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("window popped from an empty queue");

   // a window pushed into the queue must come from an accepted input transaction
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      q_push |-> $past(req_tvalid && req_tready))
      else $error("window pushed without a preceding input transaction");

   a_reset_clears_out: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered straight after reset");

endmodule

`default_nettype wire
